/* rtl/core/rrts_pkg.sv */
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared sizes, command and status codes for the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // table geometry
  localparam int TASK_SLOTS = 8;
  localparam int EVENT_BITS = 16;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  // event bits that the 16-bit mask field can reach
  localparam int EV_USE     = (EVENT_BITS < 16) ? EVENT_BITS : 16;

  // field widths
  localparam int CMD_W    = 3;
  localparam int MASK_W   = 16;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 3;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  typedef logic [SLOT_W-1:0]     slot_idx_t;
  typedef logic [TASK_SLOTS-1:0] slot_vec_t;
  typedef logic [EVENT_BITS-1:0] ev_t;
  typedef logic [HANDLE_W-1:0]   handle_t;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_SWITCH  = 3'd0,
    CMD_ALLOC   = 3'd1,
    CMD_WAIT    = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_EXIT    = 3'd4
  } cmd_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_IDLE = 2'd2
  } status_e;

endpackage

/* rtl/core/rrts_ram.sv */
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/round_robin_task_scheduler.sv */
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Task table with event flags and a round-robin pick of the running slot.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transaction: tuser holds the command code,
//   tdata the event mask and the task handle. m_axis returns one result per
//   command: tuser holds the status, tdata the allocated slot, the running
//   slot and the handle of the running slot.
//   Awaited events and handles live in two RAMs with registered read data; in-use and
//   runnable bits and the event-valid bits are flip-flops.
//   Commands are processed one at a time. After acceptance, switch, allocate,
//   exit and unknown codes pass through S_EXEC and S_HREAD; wait adds
//   S_WAIT_WR (read-modify-write of the awaited set), and release sweeps the
//   event RAM with one read per slot in S_REL_RD and a write-back in S_REL_WR
//   where the mask hits. S_RESP then registers the result on m_axis.
//   s_axis_tready is high only while no command is in progress, so a new
//   command is taken only once the last result is registered.
//   Reset empties the table, clears the running slot to 0 and drops any
//   pending result. A stalled receiver holds the result; the block finishes
//   the next command up to its result and then waits for the output register.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // event_mask [15:0], task_handle [31:16]
  input  logic [rrts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // cmd [2:0]
  input  logic [rrts_pkg::CMD_W-1:0]      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // allocated_slot [2:0], running_slot [5:3], running_handle [21:6], zero [23:22]
  output logic [rrts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [rrts_pkg::STATUS_W-1:0]   m_axis_tuser
);

  import rrts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT_WR,
    S_REL_RD,
    S_REL_WR,
    S_HREAD,
    S_RESP
  } state_t;

  typedef struct packed {
    logic      found;
    slot_idx_t idx;
  } pick_t;

  // next runnable slot, searching from cur+1 round and ending at cur
  function automatic pick_t pick_next(slot_vec_t flags, slot_idx_t cur);
    pick_t             res;
    logic [SLOT_W:0]   sum;
    slot_idx_t         idx;
    res = '0;
    for (int k = TASK_SLOTS; k >= 1; k--) begin
      sum = {1'b0, cur} + (SLOT_W+1)'(k);
      if (sum >= (SLOT_W+1)'(TASK_SLOTS)) begin
        sum = sum - (SLOT_W+1)'(TASK_SLOTS);
      end
      idx = sum[SLOT_W-1:0];
      if (flags[idx]) begin
        res.found = 1'b1;
        res.idx   = idx;
      end
    end
    return res;
  endfunction

  // lowest free slot
  function automatic pick_t pick_free(slot_vec_t used);
    pick_t res;
    res = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        res.found = 1'b1;
        res.idx   = SLOT_W'(i);
      end
    end
    return res;
  endfunction

  // slot number to the 3-bit result field
  function automatic logic [FIELD_W-1:0] slot_field(slot_idx_t s);
    logic [SLOT_W+FIELD_W-1:0] w;
    w = {{FIELD_W{1'b0}}, s};
    return w[FIELD_W-1:0];
  endfunction

  // 16-bit mask field to the event width
  function automatic ev_t mask_to_ev(logic [MASK_W-1:0] m);
    ev_t r;
    r = '0;
    r[EV_USE-1:0] = m[EV_USE-1:0];
    return r;
  endfunction

  state_t               state;
  logic [CMD_W-1:0]     cmd;
  ev_t                  mask;
  handle_t              handle;
  slot_idx_t            running;
  slot_idx_t            sweep;
  slot_idx_t            given;
  status_e              status;
  slot_vec_t            in_use;
  slot_vec_t            runnable;
  slot_vec_t            ev_valid;

  logic                 ev_we;
  slot_idx_t            ev_waddr;
  ev_t                  ev_wdata;
  logic                 ev_re;
  slot_idx_t            ev_raddr;
  ev_t                  ev_rdata;
  ev_t                  ev_cur;
  slot_idx_t            ev_slot;
  logic                 rel_hit;

  logic                 h_we;
  logic                 h_re;
  handle_t              h_rdata;

  slot_vec_t            sched_flags;
  pick_t                nxt;
  pick_t                free;

  // scheduling candidates; the current slot drops out after wait or exit
  always_comb begin
    sched_flags = in_use & runnable;
    if (state == S_WAIT_WR || cmd == CMD_EXIT) begin
      sched_flags[running] = 1'b0;
    end
    nxt  = pick_next(sched_flags, running);
    free = pick_free(in_use);
  end

  // awaited-event RAM access
  always_comb begin
    ev_slot  = (state == S_REL_WR) ? sweep : running;
    ev_cur   = ev_valid[ev_slot] ? ev_rdata : '0;
    rel_hit  = (ev_cur & mask) != '0;
    ev_re    = (state == S_EXEC && cmd == CMD_WAIT) || (state == S_REL_RD);
    ev_raddr = (state == S_REL_RD) ? sweep : running;
    ev_we    = (state == S_WAIT_WR) || (state == S_REL_WR && rel_hit);
    ev_waddr = ev_slot;
    ev_wdata = (state == S_WAIT_WR) ? (ev_cur | mask) : (ev_cur & ~mask);
  end

  // handle RAM access
  assign h_we = (state == S_EXEC) && (cmd == CMD_ALLOC) && free.found;
  assign h_re = (state == S_HREAD);

  rrts_ram #(
    .WIDTH (EVENT_BITS),
    .DEPTH (TASK_SLOTS)
  ) u_ev_ram (
    .clk   (clk),
    .we    (ev_we),
    .waddr (ev_waddr),
    .wdata (ev_wdata),
    .re    (ev_re),
    .raddr (ev_raddr),
    .rdata (ev_rdata)
  );

  rrts_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (TASK_SLOTS)
  ) u_handle_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (free.idx),
    .wdata (handle),
    .re    (h_re),
    .raddr (running),
    .rdata (h_rdata)
  );

  assign s_axis_tready = (state == S_IDLE);

  // command sequencer, table flags and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running       <= '0;
      in_use        <= '0;
      runnable      <= '0;
      ev_valid      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // result taken; a new one from S_RESP takes its place below
      if (m_axis_tvalid && m_axis_tready && state != S_RESP) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd    <= s_axis_tuser;
            mask   <= mask_to_ev(s_axis_tdata[MASK_W-1:0]);
            handle <= s_axis_tdata[MASK_W +: HANDLE_W];
            status <= ST_OK;
            given  <= '0;
            sweep  <= '0;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cmd)
            CMD_SWITCH: begin
              state <= S_HREAD;
              if (nxt.found) begin
                running <= nxt.idx;
              end else begin
                status <= ST_IDLE;
              end
            end
            CMD_ALLOC: begin
              state <= S_HREAD;
              if (free.found) begin
                in_use[free.idx]   <= 1'b1;
                runnable[free.idx] <= 1'b1;
                ev_valid[free.idx] <= 1'b0;
                given              <= free.idx;
              end else begin
                status <= ST_FULL;
              end
            end
            CMD_WAIT: begin
              state <= S_WAIT_WR;
            end
            CMD_RELEASE: begin
              state <= S_REL_RD;
            end
            CMD_EXIT: begin
              state             <= S_HREAD;
              in_use[running]   <= 1'b0;
              runnable[running] <= 1'b0;
              ev_valid[running] <= 1'b0;
              if (nxt.found) begin
                running <= nxt.idx;
              end else begin
                status <= ST_IDLE;
              end
            end
            default: begin
              state <= S_HREAD;
            end
          endcase
        end
        S_WAIT_WR: begin
          // awaited set written back this cycle
          ev_valid[running] <= 1'b1;
          runnable[running] <= 1'b0;
          if (nxt.found) begin
            running <= nxt.idx;
          end else begin
            status <= ST_IDLE;
          end
          state <= S_HREAD;
        end
        S_REL_RD: begin
          state <= S_REL_WR;
        end
        S_REL_WR: begin
          if (rel_hit) begin
            ev_valid[sweep] <= 1'b1;
            runnable[sweep] <= 1'b1;
          end
          if (sweep == SLOT_W'(TASK_SLOTS - 1)) begin
            state <= S_HREAD;
          end else begin
            sweep <= sweep + 1'b1;
            state <= S_REL_RD;
          end
        end
        S_HREAD: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= status;
            m_axis_tdata  <= {2'b00,
                              (in_use[running] ? h_rdata : '0),
                              slot_field(running),
                              slot_field(given)};
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/rrts_checker.sv */
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks for the round-robin task scheduler, bound to the top.
// ----------------------------------------------------------------------------
module rrts_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rrts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [rrts_pkg::STATUS_W-1:0]   m_axis_tuser
);

  import rrts_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // no result right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_FULL ||
                       m_axis_tuser == ST_IDLE))
    else $error("undefined status code");

  // a command with a status other than OK reports slot 0
  a_given_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[2:0] == 3'd0)
    else $error("allocated slot on failed command");

  // no new command taken in the cycle after one was accepted
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command accepted while busy");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/task_table_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// task_table_checker
// Watches both streams of the task scheduler, keeps its own copy of the task
// table, predicts one result per accepted command and compares each result.
// ----------------------------------------------------------------------------
module task_table_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // event_mask [15:0], task_handle [31:16]
  input  logic [rrts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // cmd [2:0]
  input  logic [rrts_pkg::CMD_W-1:0]      s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // allocated_slot [2:0], running_slot [5:3], running_handle [21:6], zero [23:22]
  input  logic [rrts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status [1:0]
  input  logic [rrts_pkg::STATUS_W-1:0]   m_axis_tuser,
  output int                              mismatches,
  output int                              outstanding,
  output int                              compared,
  output int                              full_seen,
  output int                              idle_seen
);
  import rrts_pkg::*;

  typedef struct packed {
    status_e   status;
    slot_idx_t alloc_slot;
    slot_idx_t run_slot;
    handle_t   run_handle;
  } sched_result_t;

  // shadow task table
  slot_vec_t in_use;
  slot_vec_t runnable;
  ev_t       awaited    [TASK_SLOTS];
  handle_t   handle_tab [TASK_SLOTS];
  slot_idx_t run_idx;

  sched_result_t pending_results [$];
  sched_result_t want;
  sched_result_t predicted;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    compared    = 0;
    full_seen   = 0;
    idle_seen   = 0;
  end

  // round-robin search from the slot after the running one, ending on itself
  function automatic status_e rotate_running();
    slot_idx_t idx;
    for (int k = 1; k <= TASK_SLOTS; k++) begin
      idx = slot_idx_t'((run_idx + k) % TASK_SLOTS);
      if (in_use[idx] && runnable[idx]) begin
        run_idx = idx;
        return ST_OK;
      end
    end
    return ST_IDLE;
  endfunction

  // apply one command to the shadow table and form its result
  function automatic sched_result_t advance_task_table(logic [CMD_W-1:0] code, ev_t evm,
                                                       handle_t hdl);
    sched_result_t res;
    slot_idx_t     cur;
    bit            placed;
    res.status     = ST_OK;
    res.alloc_slot = '0;
    cur            = run_idx;
    placed         = 1'b0;
    case (code)
      CMD_SWITCH: res.status = rotate_running();
      CMD_ALLOC: begin
        res.status = ST_FULL;
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (!placed && !in_use[i]) begin
            in_use[i]      = 1'b1;
            runnable[i]    = 1'b1;
            awaited[i]     = '0;
            handle_tab[i]  = hdl;
            res.alloc_slot = slot_idx_t'(i);
            res.status     = ST_OK;
            placed         = 1'b1;
          end
        end
      end
      CMD_WAIT: begin
        awaited[cur]  = awaited[cur] | evm;
        runnable[cur] = 1'b0;
        res.status    = rotate_running();
      end
      CMD_RELEASE: begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if ((awaited[i] & evm) != '0) begin
            awaited[i]  = awaited[i] & ~evm;
            runnable[i] = 1'b1;
          end
        end
      end
      CMD_EXIT: begin
        in_use[cur]   = 1'b0;
        runnable[cur] = 1'b0;
        awaited[cur]  = '0;
        res.status    = rotate_running();
      end
      default: ;
    endcase
    res.run_slot   = run_idx;
    res.run_handle = in_use[run_idx] ? handle_tab[run_idx] : '0;
    return res;
  endfunction

  task automatic compare_field(input string label, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, actual %0d", label, exp_val, act_val);
      mismatches++;
    end
  endtask

  // result side first, then the command side; latency keeps them apart
  always @(posedge clk) begin
    if (rst) begin
      in_use   = '0;
      runnable = '0;
      run_idx  = '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        awaited[i]    = '0;
        handle_tab[i] = '0;
      end
      pending_results.delete();
      outstanding = 0;
    end else begin
      // result transaction
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no command outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("status", 16'(want.status), 16'(m_axis_tuser));
          compare_field("allocated_slot", 16'(want.alloc_slot), 16'(m_axis_tdata[2:0]));
          compare_field("running_slot", 16'(want.run_slot), 16'(m_axis_tdata[5:3]));
          compare_field("running_handle", want.run_handle, m_axis_tdata[21:6]);
          compare_field("padding", 16'd0, 16'(m_axis_tdata[23:22]));
          compared++;
        end
      end
      // command transaction
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = advance_task_table(s_axis_tuser, ev_t'(s_axis_tdata[EV_USE-1:0]),
                                       s_axis_tdata[31:16]);
        if (predicted.status == ST_FULL) full_seen++;
        if (predicted.status == ST_IDLE) idle_seen++;
        pending_results.push_back(predicted);
      end
      outstanding = pending_results.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives scheduler commands with random gaps and result stalls: a directed
// run through the corner cases, then phases that fill, churn and drain the
// task table. Checking is done by task_table_checker.
// ----------------------------------------------------------------------------
module testbench;
  import rrts_pkg::*;

  localparam int RANDOM_COMMANDS = 950;
  localparam int DRAIN_CYCLES    = 3 + 2 * TASK_SLOTS + 24;
  localparam int CYCLE_LIMIT     = 400000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  int mismatches;
  int outstanding;
  int compared;
  int full_seen;
  int idle_seen;
  int cycle_count = 0;
  int issued_per_code [8];
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  round_robin_task_scheduler uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  task_table_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .compared      (compared),
    .full_seen     (full_seen),
    .idle_seen     (idle_seen)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: a fresh random stall, while receiver idling is on, before every result transaction
  initial begin : result_sink
    int stall;
    while (rst) @(negedge clk);
    forever begin
      stall = receiver_idles ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  // one command transaction; called and returns at a falling edge
  task automatic issue_command(input logic [CMD_W-1:0] code, input logic [15:0] evm,
                               input logic [15:0] hdl);
    int gap;
    gap = sender_idles ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= code;
    s_axis_tdata  <= {hdl, evm};
    do @(posedge clk); while (!s_axis_tready);
    issued_per_code[code]++;
    @(negedge clk);
  endtask

  // mostly one or two low event bits so that waits and releases meet
  function automatic logic [15:0] draw_event_mask();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      4:       return 16'(1) << $urandom_range(0, 15);
      default: return (16'(1) << $urandom_range(0, 4)) | (16'(1) << $urandom_range(0, 4));
    endcase
  endfunction

  // phase 0 fills the table, phase 1 churns, phase 2 drains it
  function automatic logic [CMD_W-1:0] draw_command(input int phase);
    int r;
    int t_alloc;
    int t_switch;
    int t_wait;
    int t_release;
    int t_exit;
    r = $urandom_range(0, 99);
    case (phase)
      0:       begin t_alloc = 40; t_switch = 58; t_wait = 72; t_release = 86; t_exit = 97; end
      1:       begin t_alloc = 22; t_switch = 45; t_wait = 65; t_release = 84; t_exit = 97; end
      default: begin t_alloc = 10; t_switch = 30; t_wait = 55; t_release = 70; t_exit = 97; end
    endcase
    if (r < t_alloc)   return CMD_ALLOC;
    if (r < t_switch)  return CMD_SWITCH;
    if (r < t_wait)    return CMD_WAIT;
    if (r < t_release) return CMD_RELEASE;
    if (r < t_exit)    return CMD_EXIT;
    return CMD_W'($urandom_range(5, 7));
  endfunction

  initial begin : stimulus
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table: nothing runnable, waits and exits on a free slot
    issue_command(CMD_SWITCH,  16'h0000, 16'h0000);
    issue_command(CMD_WAIT,    16'hFFFF, 16'h0000);
    issue_command(CMD_EXIT,    16'h0000, 16'hFFFF);
    issue_command(CMD_RELEASE, 16'h0000, 16'h0000);
    issue_command(CMD_RELEASE, 16'hFFFF, 16'h0000);
    // fill every slot, then one more for the full table
    issue_command(CMD_ALLOC, 16'hFFFF, 16'h0000);
    issue_command(CMD_ALLOC, 16'h0000, 16'hFFFF);
    issue_command(CMD_ALLOC, 16'h1234, 16'h5555);
    issue_command(CMD_ALLOC, 16'h0000, 16'hAAAA);
    issue_command(CMD_ALLOC, 16'h0000, 16'h0001);
    issue_command(CMD_ALLOC, 16'h0000, 16'h8000);
    issue_command(CMD_ALLOC, 16'h0000, 16'h1234);
    issue_command(CMD_ALLOC, 16'h0000, 16'hFEDC);
    issue_command(CMD_ALLOC, 16'h0000, 16'h4321);
    // switching, empty and non-empty waits and releases
    issue_command(CMD_SWITCH,  16'hFFFF, 16'hFFFF);
    issue_command(CMD_WAIT,    16'h0000, 16'h0000);
    issue_command(CMD_WAIT,    16'h8001, 16'h0000);
    issue_command(CMD_RELEASE, 16'h0000, 16'h0000);
    issue_command(CMD_RELEASE, 16'h0001, 16'h0000);
    issue_command(CMD_EXIT,    16'h0000, 16'h0000);
    // undefined codes change nothing
    issue_command(3'd5, 16'hFFFF, 16'hFFFF);
    issue_command(3'd6, 16'h0F0F, 16'hF0F0);
    issue_command(3'd7, 16'h0000, 16'h0000);
    issue_command(CMD_ALLOC,   16'h0000, 16'hBEEF);
    issue_command(CMD_RELEASE, 16'h8000, 16'h0000);

    // random phases with idling switched on and off in stretches
    for (int n = 0; n < RANDOM_COMMANDS; n++) begin
      if (n % 40 == 0) begin
        sender_idles   <= ($urandom_range(0, 3) != 0);
        receiver_idles <= ($urandom_range(0, 3) != 0);
      end
      issue_command(draw_command((n / 120) % 3), draw_event_mask(), 16'($urandom));
    end
    s_axis_tvalid <= 1'b0;

    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("commands: %0d switch, %0d allocate, %0d wait, %0d release, %0d exit, %0d undefined",
             issued_per_code[0], issued_per_code[1], issued_per_code[2], issued_per_code[3],
             issued_per_code[4], issued_per_code[5] + issued_per_code[6] + issued_per_code[7]);
    $display("results compared: %0d, table full %0d times, nothing runnable %0d times",
             compared, full_seen, idle_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* round_robin_task_scheduler.f */
rtl/core/rrts_pkg.sv
rtl/core/rrts_ram.sv
rtl/core/round_robin_task_scheduler.sv
rtl/core/rrts_checker.sv
tb/task_table_checker.sv
tb/testbench.sv
